>>> design/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types and constants for the RGB to YUV pixel packer: output format
// codes, register indexes and the integer BT.601 coefficients.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

    typedef enum logic [1:0] {
        FMT_NONE     = 2'd0,
        FMT_NV16     = 2'd1,
        FMT_UYV565   = 2'd2,
        FMT_AYUV4444 = 2'd3
    } t_format;

    // register index as decoded from paddr[2]
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    localparam logic [12:0] WIDTH_RESET = 13'd640;

    // coefficient magnitudes; signs are applied in the adder terms
    localparam logic [16:0] C_Y_R = 17'd66;
    localparam logic [16:0] C_Y_G = 17'd129;
    localparam logic [16:0] C_Y_B = 17'd25;
    localparam logic [16:0] C_U_R = 17'd38;
    localparam logic [16:0] C_U_G = 17'd74;
    localparam logic [16:0] C_U_B = 17'd112;
    localparam logic [16:0] C_V_R = 17'd112;
    localparam logic [16:0] C_V_G = 17'd94;
    localparam logic [16:0] C_V_B = 17'd18;

    localparam logic [16:0] C_ROUND       = 17'd128;
    // 128 * 256 added before the shift keeps the chroma sums non-negative
    localparam logic [16:0] C_CHROMA_BIAS = 17'd32768;
    localparam logic [8:0]  C_Y_OFFSET    = 9'd16;
    localparam logic [8:0]  C_MAX_BYTE    = 9'd255;

endpackage

>>> design/rgb_to_yuv_pixel_packer_top.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv_pixel_packer_top
// Converts RGB pixels to BT.601 YUV, one per clock while the receiver keeps up,
// and packs each as NV16 bytes, a UYV565 word or an AYUV4444 word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_valid / o_ready carries i_red, i_green, i_blue.
//   Output channel o_valid / i_ready carries o_luma, o_chroma, o_packed_word.
//   A request is taken on a clock edge where valid and ready are both high.
//   Pixels arrive in raster order; line_width sets the row length so the
//   NV16 column parity restarts on every row.
//   A pixel passes one input register, then the conversion feeding the output
//   register. Throughput is one pixel per clock while the receiver keeps up,
//   set by the single conversion stage.
//   With output_format 0 a pixel produces no output but still advances the
//   column count.
//   When the receiver stalls, the output register holds its word and the
//   input register takes one more pixel before o_ready drops.
//   Synchronous reset empties both registers, clears the column count and
//   the NV16 chroma holds, and loads output_format = NV16, line_width = 640.
//   Registers (APB, pready always high): 0x0 output_format, 0x4 line_width.
//   Write them only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_to_yuv_pixel_packer_top
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_luma,
    output logic [7:0]  o_chroma,
    output logic [15:0] o_packed_word
);

    localparam int CW = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;

    // configuration
    t_format     r_format;
    logic [12:0] r_width;
    logic        cfg_wr;

    // pipeline
    logic        r_s1_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic        r_out_valid;
    logic [7:0]  r_luma;
    logic [7:0]  r_chroma;
    logic [15:0] r_packed;
    logic        out_free;
    logic        s1_fire;

    // state
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [7:0]    r_held_u;
    logic [7:0]    r_held_v;
    logic [7:0]    n_held_u;
    logic [7:0]    n_held_v;
    logic [7:0]    n_luma;
    logic [7:0]    n_chroma;
    logic [15:0]   n_packed;

    // datapath
    logic [16:0] red_x;
    logic [16:0] green_x;
    logic [16:0] blue_x;
    logic [16:0] y_sum;
    logic [16:0] u_sum;
    logic [16:0] v_sum;
    logic [8:0]  y_full;
    logic [7:0]  y_val;
    logic [7:0]  u_val;
    logic [7:0]  v_val;
    logic [8:0]  avg_sum;
    logic [7:0]  avg_held;
    logic [7:0]  avg_new;
    logic        col_even;
    logic [WW-1:0] width_eff;
    logic [WW-1:0] col_inc;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_NV16;
            r_width  <= WIDTH_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FORMAT: r_format <= t_format'(pwdata[1:0]);
                REG_WIDTH:  r_width  <= pwdata[12:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FORMAT: prdata = {30'd0, r_format};
            REG_WIDTH:  prdata = {19'd0, r_width};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_free = !r_out_valid || i_ready;
    assign s1_fire  = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // ---------------- color conversion ----------------
    assign red_x   = {9'd0, r_red};
    assign green_x = {9'd0, r_green};
    assign blue_x  = {9'd0, r_blue};

    assign y_sum = C_Y_R * red_x + C_Y_G * green_x + C_Y_B * blue_x + C_ROUND;
    // chroma sums stay within 0..65535 after the bias, so 17-bit wrap is exact
    assign u_sum = C_CHROMA_BIAS + C_ROUND + C_U_B * blue_x
                   - C_U_R * red_x - C_U_G * green_x;
    assign v_sum = C_CHROMA_BIAS + C_ROUND + C_V_R * red_x
                   - C_V_G * green_x - C_V_B * blue_x;

    assign y_full = y_sum[16:8] + C_Y_OFFSET;
    assign y_val  = (y_full > C_MAX_BYTE) ? 8'hFF : y_full[7:0];
    // biased chroma lands in 16..240, never above a byte
    assign u_val  = u_sum[15:8];
    assign v_val  = v_sum[15:8];

    // ---------------- NV16 chroma averaging ----------------
    assign col_even = !r_col[0];
    assign avg_held = col_even ? r_held_u : r_held_v;
    assign avg_new  = col_even ? u_val : v_val;
    assign avg_sum  = {1'b0, avg_held} + {1'b0, avg_new};

    // ---------------- column counter ----------------
    always_comb begin
        width_eff = WW'(r_width);
        if (width_eff == '0) begin
            width_eff = WW'(1);
        end
        if (width_eff > WW'(MAX_LINE_WIDTH)) begin
            width_eff = WW'(MAX_LINE_WIDTH);
        end
        col_inc = WW'({1'b0, r_col}) + WW'(1);
        n_col   = (col_inc >= width_eff) ? '0 : col_inc[CW-1:0];
    end

    // ---------------- output formatting ----------------
    always_comb begin
        n_held_u = r_held_u;
        n_held_v = r_held_v;
        n_luma   = 8'd0;
        n_chroma = 8'd0;
        n_packed = 16'd0;
        case (r_format)
            FMT_NV16: begin
                n_luma   = y_val;
                n_chroma = (avg_held != 8'd0) ? avg_sum[8:1] : avg_new;
                if (col_even) begin
                    n_held_v = v_val;
                end else begin
                    n_held_u = u_val;
                end
            end
            FMT_UYV565: begin
                n_packed = {u_val[7:3], y_val[7:2], v_val[7:3]};
            end
            FMT_AYUV4444: begin
                n_packed = {4'h1, y_val[7:4], u_val[7:4], v_val[7:4]};
            end
            default: begin
                n_packed = 16'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_held_u    <= 8'd0;
            r_held_v    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid && (r_format != FMT_NONE);
            end
            if (s1_fire) begin
                r_col    <= n_col;
                r_held_u <= n_held_u;
                r_held_v <= n_held_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_luma   <= n_luma;
            r_chroma <= n_chroma;
            r_packed <= n_packed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_luma        = r_luma;
    assign o_chroma      = r_chroma;
    assign o_packed_word = r_packed;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives RGB pixels into the pixel packer under several format and row-width
// settings, predicts each NV16 byte pair or packed 16-bit word in a
// scoreboard model, and compares every output request field by field.
// ----------------------------------------------------------------------------
module testbench
    import rgb2yuv_pkg::*;
();

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PIXELS  = 1950;
    // last stretch of the random part runs with no idling
    localparam int QUIET_TAIL     = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0]  luma;
        logic [7:0]  chroma;
        logic [15:0] packed_word;
    } t_yuv_out;

    class yuv_packer_model;
        t_format     out_format;
        logic [12:0] line_width;
        int          column;
        logic [7:0]  held_u;
        logic [7:0]  held_v;
        t_yuv_out    expected_out[$];
        int          errors;

        function new();
            out_format = FMT_NV16;
            line_width = WIDTH_RESET;
            column     = 0;
            held_u     = '0;
            held_v     = '0;
            errors     = 0;
        endfunction

        function void set_register(logic sel, logic [31:0] value);
            if (sel == REG_FORMAT) begin
                out_format = t_format'(value[1:0]);
            end else begin
                line_width = value[12:0];
            end
        endfunction

        function int clamp_byte(int x);
            return (x > 255) ? 255 : x;
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int       ri, gi, bi;
            int       y, u, v, c, w;
            t_yuv_out want;
            ri   = r;
            gi   = g;
            bi   = b;
            y    = clamp_byte(((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16);
            // bias by 128*256 so the floor shift never sees a negative sum
            u    = (-38 * ri - 74 * gi + 112 * bi + 128 + 32768) >>> 8;
            v    = (112 * ri - 94 * gi - 18 * bi + 128 + 32768) >>> 8;
            want = '0;
            w    = line_width;
            if (w == 0) begin
                w = 1;
            end
            if (w > MAX_LINE_WIDTH) begin
                w = MAX_LINE_WIDTH;
            end
            case (out_format)
                FMT_NV16: begin
                    if ((column % 2) == 0) begin
                        c      = (held_u != 0) ? (int'(held_u) + u) / 2 : u;
                        held_v = v[7:0];
                    end else begin
                        c      = (held_v != 0) ? (int'(held_v) + v) / 2 : v;
                        held_u = u[7:0];
                    end
                    c           = clamp_byte(c);
                    want.luma   = y[7:0];
                    want.chroma = c[7:0];
                    expected_out.push_back(want);
                end
                FMT_UYV565: begin
                    u                = clamp_byte(u);
                    v                = clamp_byte(v);
                    want.packed_word = {u[7:3], y[7:2], v[7:3]};
                    expected_out.push_back(want);
                end
                FMT_AYUV4444: begin
                    u                = clamp_byte(u);
                    v                = clamp_byte(v);
                    want.packed_word = {4'h1, y[7:4], u[7:4], v[7:4]};
                    expected_out.push_back(want);
                end
                default: ;
            endcase
            column = (column + 1 >= w) ? 0 : column + 1;
        endfunction

        function void check_result(logic [7:0] luma, logic [7:0] chroma,
                                   logic [15:0] packed_word);
            t_yuv_out want;
            if (expected_out.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected output: luma %0d chroma %0d packed %h",
                             luma, chroma, packed_word);
                end
            end else begin
                want = expected_out.pop_front();
                if (want.luma !== luma || want.chroma !== chroma ||
                    want.packed_word !== packed_word) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: luma %0d/%0d chroma %0d/%0d packed %h/%h %s",
                                 want.luma, luma, want.chroma, chroma,
                                 want.packed_word, packed_word, "(expected/actual)");
                    end
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_luma;
    logic [7:0]  o_chroma;
    logic [15:0] o_packed_word;

    yuv_packer_model packer = new();
    bit              idle_on;
    int              quiet_cycles;

    rgb_to_yuv_pixel_packer_top #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_luma       (o_luma),
        .o_chroma     (o_chroma),
        .o_packed_word(o_packed_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                packer.note_pixel(i_red, i_green, i_blue);
            end
            if (o_valid && i_ready) begin
                packer.check_result(o_luma, o_chroma, o_packed_word);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver side: stall output requests in random bursts
    initial begin
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [23:0] rgb);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_red, i_green, i_blue} <= rgb;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        packer.set_register(sel, value);
        @(posedge i_clk);
    endtask

    // drop valid, wait out every expected output, then let the pipe empty
    task automatic settle(input int extra);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (packer.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        int          sent;
        int          run_len;
        t_format     fmt;
        logic [12:0] width;
        logic [7:0]  r, g, b;

        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_valid <= 1'b0;
        i_red   <= '0;
        i_green <= '0;
        i_blue  <= '0;
        idle_on = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: NV16, first column starts with empty chroma holds
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFF0000);
        send_pixel(24'h00FF00);
        send_pixel(24'h0000FF);
        send_pixel(24'hFFFF00);
        settle(4);

        // no output, but the column still advances
        write_reg(REG_FORMAT, FMT_NONE);
        send_pixel(24'h00FFFF);
        send_pixel(24'hFF00FF);
        send_pixel(24'h808080);
        settle(4);

        // narrow the row below the current column: wraps on the next pixel
        write_reg(REG_FORMAT, FMT_UYV565);
        write_reg(REG_WIDTH, 32'd2);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFF0000);
        send_pixel(24'h0000FF);
        settle(4);

        write_reg(REG_FORMAT, FMT_AYUV4444);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF00FF);
        settle(4);

        // zero width behaves as one pixel per row, so every column is even
        write_reg(REG_FORMAT, FMT_NV16);
        write_reg(REG_WIDTH, 32'd0);
        send_pixel(24'hFF0000);
        send_pixel(24'h0000FF);
        send_pixel(24'h0CC84D);
        settle(4);

        // width above the maximum is clipped to it
        write_reg(REG_WIDTH, 32'h1FFF);
        send_pixel(24'h00FF00);
        send_pixel(24'hC80A5A);
        settle(4);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       fmt = FMT_NONE;
                1, 2, 3: fmt = FMT_UYV565;
                4, 5, 6: fmt = FMT_AYUV4444;
                default: fmt = FMT_NV16;
            endcase
            case ($urandom_range(0, 9))
                0:       width = 13'd1;
                1:       width = 13'd2;
                2:       width = 13'd3;
                3:       width = 13'd4096;
                4:       width = 13'd0;
                5:       width = 13'h1FFF;
                6:       width = 13'($urandom_range(4, 16));
                7:       width = WIDTH_RESET;
                default: width = 13'($urandom_range(1, 64));
            endcase
            idle_on = (sent < RANDOM_PIXELS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            write_reg(REG_FORMAT, fmt);
            write_reg(REG_WIDTH, width);
            run_len = $urandom_range(10, 120);
            if (run_len > RANDOM_PIXELS - sent) begin
                run_len = RANDOM_PIXELS - sent;
            end
            repeat (run_len) begin
                if ($urandom_range(0, 7) == 0) begin
                    r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    r = 8'($urandom_range(0, 255));
                    g = 8'($urandom_range(0, 255));
                    b = 8'($urandom_range(0, 255));
                end
                send_pixel({r, g, b});
                sent++;
            end
            settle(4);
        end

        idle_on = 1'b0;
        settle(10);
        if (packer.errors == 0 && packer.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
